// ===== design/tape_pulse_bit_player_core_assert.svh =====
// ----------------------------------------------------------------------------
// Tape pulse bit player - assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef TAPE_PULSE_BIT_PLAYER_CORE_ASSERT_SVH
`define TAPE_PULSE_BIT_PLAYER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tpb_pkg.sv =====
// ----------------------------------------------------------------------------
// Tape pulse bit player - package
// Types, codes and reset values shared by the player modules.
// ----------------------------------------------------------------------------
package tpb_pkg;

    // Default tape store depth in bits.
    localparam int TAPE_BITS_DEFAULT = 1048576;

    // Field widths.
    localparam int TIME_W      = 32;
    localparam int POS_W       = 20;
    localparam int LEN_W       = 21;
    localparam int SHORT_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 8;

    // Register reset values.
    localparam logic [LEN_W-1:0]   TAPE_LENGTH_RST   = 21'd0;
    localparam logic [SHORT_W-1:0] LOW_TIME_RST      = 16'd120;
    localparam logic [SHORT_W-1:0] ZERO_BIT_END_RST  = 16'd1250;
    localparam logic [SHORT_W-1:0] ONE_BIT_EXTRA_RST = 16'd532;
    localparam logic [TIME_W-1:0]  GAP_LIMIT_RST     = 32'd5040;

    // Request kinds carried in tuser.
    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } tpb_op_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAPE_LENGTH   = 3'd0,
        CFG_LOW_TIME      = 3'd1,
        CFG_ZERO_BIT_END  = 3'd2,
        CFG_ONE_BIT_EXTRA = 3'd3,
        CFG_GAP_LIMIT     = 3'd4
    } tpb_cfg_idx_t;

    // Player phase: two lead-in reads, idle, or a bit being played.
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEAD_A = 3'd1,
        PH_LEAD_B = 3'd2,
        PH_ZERO   = 3'd3,
        PH_ONE    = 3'd4
    } tpb_phase_t;

    typedef struct packed {
        logic [LEN_W-1:0]   tape_length;
        logic [SHORT_W-1:0] low_time;
        logic [SHORT_W-1:0] zero_bit_end;
        logic [SHORT_W-1:0] one_bit_extra;
        logic [TIME_W-1:0]  gap_limit;
    } tpb_cfg_t;

    typedef struct packed {
        logic rewound;
        logic level;
    } tpb_result_t;

endpackage

// ===== design/tape_pulse_bit_player_core.sv =====
// ----------------------------------------------------------------------------
// Tape pulse bit player - top level
// Plays a stored bit tape as pulse-width cassette input at CPU timestamps.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel. A write request (tuser high) stores
// one tape bit and returns nothing. A read request (tuser low) returns one
// result on the m_axis channel: the cassette level at the request's cycle
// count and a flag telling whether this read wrapped the tape position.
// Configuration is written through the cfg channel, which is always ready;
// it should only be written while no read is in flight.
// A read passes through the memory stage, where the tape memory is read as
// the request is taken, and the output register, which the playback state
// update loads once it is free. One request is taken per cycle, writes and
// reads alike, unless the result side stalls: one request a cycle sustained.
// The next read's memory address is forwarded from the position update of
// the read ahead of it, so back-to-back reads need no bubble.
// Reset clears the playback state and restores the register defaults; the
// tape memory is not cleared and must be written before it is played.
// When the receiver stalls, the result waits in the output register and the
// read behind it waits in the memory stage; only then is s_axis_tready low.
// ----------------------------------------------------------------------------
`include "tape_pulse_bit_player_core_assert.svh"

module tape_pulse_bit_player_core #(
    parameter int TAPE_BITS = tpb_pkg::TAPE_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Request channel.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [31:0] cycle_count, [51:32] tape_address, [52] tape_bit, [55:53] zero
    input  logic [tpb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic                            s_axis_tuser,
    // Result channel.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] level, [1] rewound, [7:2] zero
    output logic [tpb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tpb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tpb_pkg::*;

    localparam int AddrW = $clog2(TAPE_BITS);

    // Configuration registers.
    tpb_cfg_t cfg_reg, cfg_next;

    // Memory stage: a read waiting for its tape bit.
    logic                s1_valid_reg, s1_valid_next;
    logic [TIME_W-1:0]   s1_now_reg, s1_now_next;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    tpb_result_t         out_res_reg, out_res_next;

    logic                in_accept;
    logic                out_free;
    logic                s1_fire;
    logic [TIME_W-1:0]   in_cycle_count;
    logic [POS_W-1:0]    in_tape_address;
    logic                in_tape_bit;
    logic                ram_we;
    logic [AddrW-1:0]    ram_waddr;
    logic [AddrW-1:0]    ram_raddr;
    logic                ram_rdata;
    tpb_result_t         eng_res;
    logic [POS_W-1:0]    eng_pos;

    assign in_cycle_count  = s_axis_tdata[TIME_W-1:0];
    assign in_tape_address = s_axis_tdata[TIME_W+POS_W-1:TIME_W];
    assign in_tape_bit     = s_axis_tdata[TIME_W+POS_W];

    // Handshakes. The output register frees when empty or being drained.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s1_fire       = s1_valid_reg && out_free;
    assign s_axis_tready = !s1_valid_reg || out_free;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // Writes go straight to the tape memory; addresses past the store are dropped.
    assign ram_we    = in_accept && (s_axis_tuser == OP_WRITE)
                       && (32'(in_tape_address) < 32'(TAPE_BITS));
    assign ram_waddr = AddrW'(in_tape_address);

    tpb_ram #(
        .WIDTH (1),
        .DEPTH (TAPE_BITS)
    ) u_tape_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_tape_bit),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tpb_engine #(
        .TAPE_BITS (TAPE_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .commit   (s1_fire),
        .now      (s1_now_reg),
        .cfg      (cfg_reg),
        .tape_bit (ram_rdata),
        .rd_addr  (ram_raddr),
        .result   (eng_res),
        .position (eng_pos)
    );

    // Configuration decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TAPE_LENGTH:   cfg_next.tape_length   = cfg_data[LEN_W-1:0];
                CFG_LOW_TIME:      cfg_next.low_time      = cfg_data[SHORT_W-1:0];
                CFG_ZERO_BIT_END:  cfg_next.zero_bit_end  = cfg_data[SHORT_W-1:0];
                CFG_ONE_BIT_EXTRA: cfg_next.one_bit_extra = cfg_data[SHORT_W-1:0];
                CFG_GAP_LIMIT:     cfg_next.gap_limit     = cfg_data[TIME_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Pipeline control.
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_now_next    = s1_now_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        if (in_accept && (s_axis_tuser == OP_READ))
        begin
            s1_valid_next = 1'b1;
            s1_now_next   = in_cycle_count;
        end
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
            out_res_next   = eng_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tape_length   <= TAPE_LENGTH_RST;
            cfg_reg.low_time      <= LOW_TIME_RST;
            cfg_reg.zero_bit_end  <= ZERO_BIT_END_RST;
            cfg_reg.one_bit_extra <= ONE_BIT_EXTRA_RST;
            cfg_reg.gap_limit     <= GAP_LIMIT_RST;
            s1_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_now_reg  <= s1_now_next;
        out_res_reg <= out_res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, out_res_reg.rewound, out_res_reg.level};

    // A read held in the memory stage behind a full output blocks new requests,
    // so no write can change the tape bit it is waiting on.
    `TPB_ASSERT_SAME(a_stall_blocks_input, s1_valid_reg && out_valid_reg && !m_axis_tready, !s_axis_tready, "request taken while memory stage stalled")

    // A write request never occupies the memory stage.
    `TPB_ASSERT_NEXT(a_write_skips_stage, in_accept && (s_axis_tuser == OP_WRITE), !s1_valid_reg, "write request entered the memory stage")

    // A wrapping read leaves the tape position at zero.
    `TPB_ASSERT_NEXT(a_rewind_clears_pos, s1_fire && eng_res.rewound, eng_pos == '0, "tape position not zero after rewind")

    // The playback position always addresses a real tape entry.
    `TPB_ASSERT_SAME(a_pos_in_store, 1'b1, 32'(eng_pos) < 32'(TAPE_BITS), "tape position beyond tape store")

endmodule

// ===== design/tpb_ram.sv =====
// ----------------------------------------------------------------------------
// Tape pulse bit player - generic RAM
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module tpb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/tpb_engine.sv =====
// ----------------------------------------------------------------------------
// Tape pulse bit player - playback engine
// Holds the phase, timestamps and tape position and updates them per read.
// ----------------------------------------------------------------------------
module tpb_engine #(
    parameter int TAPE_BITS = tpb_pkg::TAPE_BITS_DEFAULT,
    localparam int AddrW = $clog2(TAPE_BITS)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         commit,
    input  logic [tpb_pkg::TIME_W-1:0]   now,
    input  tpb_pkg::tpb_cfg_t            cfg,
    input  logic                         tape_bit,
    output logic [AddrW-1:0]             rd_addr,
    output tpb_pkg::tpb_result_t         result,
    output logic [tpb_pkg::POS_W-1:0]    position
);
    import tpb_pkg::*;

    // Wrap point from the store depth, capped at the position range.
    localparam logic [LEN_W-1:0] CapLim =
        (TAPE_BITS < (1 << POS_W)) ? LEN_W'(TAPE_BITS) : LEN_W'(1 << POS_W);

    tpb_phase_t          phase_reg, phase_next;
    logic [TIME_W-1:0]   last_read_reg, last_read_next;
    logic [TIME_W-1:0]   low_end_reg, low_end_next;
    logic [TIME_W-1:0]   bit_end_reg, bit_end_next;
    logic [POS_W-1:0]    pos_reg, pos_next;

    logic [TIME_W-1:0]   gap_diff;
    logic [TIME_W-1:0]   low_diff;
    logic [TIME_W-1:0]   end_diff;
    logic                gap_hit;
    logic                playing;
    logic                fetch;
    logic                ended;
    logic [SHORT_W:0]    pulse_len;
    logic [LEN_W-1:0]    limit;
    logic [LEN_W-1:0]    pos_inc;
    logic                wrap;
    logic [POS_W-1:0]    pos_fetch;

    always_comb
    begin
        gap_diff  = now - last_read_reg;
        low_diff  = now - low_end_reg;
        end_diff  = now - bit_end_reg;
        gap_hit   = gap_diff > cfg.gap_limit;
        playing   = (phase_reg == PH_ZERO) || (phase_reg == PH_ONE);
        fetch     = !gap_hit && (phase_reg != PH_LEAD_A)
                    && (cfg.tape_length != '0) && !playing;
        ended     = (end_diff != '0) && !end_diff[TIME_W-1];
        pulse_len = {1'b0, cfg.zero_bit_end}
                    + (tape_bit ? {1'b0, cfg.one_bit_extra} : '0);
        limit     = (cfg.tape_length < CapLim) ? cfg.tape_length : CapLim;
        pos_inc   = {1'b0, pos_reg} + LEN_W'(1);
        wrap      = pos_inc >= limit;
        pos_fetch = wrap ? '0 : pos_inc[POS_W-1:0];
    end

    always_comb
    begin
        phase_next     = phase_reg;
        last_read_next = now;
        low_end_next   = low_end_reg;
        bit_end_next   = bit_end_reg;
        pos_next       = pos_reg;
        result.level   = 1'b0;
        result.rewound = 1'b0;
        if (gap_hit)
        begin
            phase_next   = ended ? PH_IDLE : PH_LEAD_A;
            low_end_next = '0;
        end
        else if (phase_reg == PH_LEAD_A)
        begin
            phase_next = ended ? PH_IDLE : PH_LEAD_B;
        end
        else if (fetch)
        begin
            // A freshly started pulse never ends before now, so it never ends here.
            phase_next     = tape_bit ? PH_ONE : PH_ZERO;
            low_end_next   = now + TIME_W'(cfg.low_time);
            bit_end_next   = now + TIME_W'(pulse_len);
            pos_next       = pos_fetch;
            result.rewound = wrap;
            result.level   = (cfg.low_time == '0) && (pulse_len != '0);
        end
        else
        begin
            result.level = playing && !low_diff[TIME_W-1] && end_diff[TIME_W-1];
            phase_next   = ended ? PH_IDLE : phase_reg;
        end
    end

    // Forward the advanced position so a read entering now sees the right bit.
    assign rd_addr  = AddrW'((commit && fetch) ? pos_fetch : pos_reg);
    assign position = pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            last_read_reg <= '0;
            low_end_reg   <= '0;
            bit_end_reg   <= '0;
            pos_reg       <= '0;
        end
        else if (commit)
        begin
            phase_reg     <= phase_next;
            last_read_reg <= last_read_next;
            low_end_reg   <= low_end_next;
            bit_end_reg   <= bit_end_next;
            pos_reg       <= pos_next;
        end
    end

endmodule

// ===== bench/tape_pulse_bit_player_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tape pulse bit player - testbench
// Self-checking bench: plays timestamped read and tape-write requests through
// the core and compares each read result with its own playback predictor.
// ----------------------------------------------------------------------------
// The bench runs a short table of directed requests first, then several
// random phases, each opened by a full register rewrite while the core is
// idle. Every request is predicted in issue order, and each read's expected
// result is queued at once; results are checked in order as they arrive.
// Both channels idle at random, and the result side holds off once for a
// long stretch so that the core fills up and stalls its request channel.
// ----------------------------------------------------------------------------
module tape_pulse_bit_player_core_tb;

    import tpb_pkg::*;

    // A small store makes out-of-range writes reachable. It is below 2^20,
    // so it is always the tighter of the two caps on the tape position.
    localparam int TB_TAPE_BITS    = 1024;
    localparam int PHASES          = 10;
    localparam int PHASE_REQUESTS  = 113;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 300000;
    localparam int HOLD_AT_RESULT  = 200;
    localparam int HOLD_CYCLES     = 80;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tape_pulse_bit_player_core #(
        .TAPE_BITS(TB_TAPE_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Playback predictor state: a private copy of the registers, the phase,
    // the three timestamps, the position and the tape itself.
    // ------------------------------------------------------------------------
    tpb_cfg_t         player_cfg;
    tpb_phase_t       play_phase;
    logic [31:0]      last_read_t;
    logic [31:0]      low_end_t;
    logic [31:0]      bit_end_t;
    logic [POS_W-1:0] tape_pos;
    bit               tape_bits    [TB_TAPE_BITS];
    bit               tape_written [TB_TAPE_BITS];

    // Results still owed by the core, oldest first.
    tpb_result_t      pending_levels [$];
    int               failures;
    int               requests_sent;
    logic [31:0]      stim_t;

    // One row of the directed table: either a register write or a request,
    // optionally with its result typed in by hand.
    typedef struct {
        bit           is_cfg;
        tpb_cfg_idx_t idx;
        logic [31:0]  value;
        tpb_op_t      op;
        logic [31:0]  cyc;
        logic [19:0]  addr;
        logic         bt;
        bit           known;
        tpb_result_t  res;
    } stim_row_t;

    stim_row_t directed_rows [$];

    function automatic stim_row_t rd(logic [31:0] cyc);
        stim_row_t row;
        row = '{is_cfg: 1'b0, idx: CFG_TAPE_LENGTH, value: '0, op: OP_READ, cyc: cyc,
                addr: '0, bt: 1'b0, known: 1'b0, res: '0};
        return row;
    endfunction

    function automatic stim_row_t rd_known(logic [31:0] cyc, logic level, logic rewound);
        stim_row_t row;
        row = rd(cyc);
        row.known       = 1'b1;
        row.res.level   = level;
        row.res.rewound = rewound;
        return row;
    endfunction

    function automatic stim_row_t wr(logic [19:0] addr, logic bt);
        stim_row_t row;
        row      = rd(32'd0);
        row.op   = OP_WRITE;
        row.addr = addr;
        row.bt   = bt;
        return row;
    endfunction

    function automatic stim_row_t cf(tpb_cfg_idx_t idx, logic [31:0] value);
        stim_row_t row;
        row        = rd(32'd0);
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.value  = value;
        return row;
    endfunction

    // Wraparound time order: the difference is read as a signed number.
    function automatic bit is_before(logic [31:0] now, logic [31:0] t);
        logic [31:0] d;
        d = now - t;
        return d[31];
    endfunction

    function automatic bit is_after(logic [31:0] now, logic [31:0] t);
        logic [31:0] d;
        d = now - t;
        return (d != 32'd0) && !d[31];
    endfunction

    // Advances the player by one read at timestamp now and returns the level
    // the CPU should see, together with the rewind flag.
    function automatic tpb_result_t play_read(logic [31:0] now);
        tpb_result_t res;
        logic        fetched;
        int unsigned cap;
        res = '0;
        if (now - last_read_t > player_cfg.gap_limit) begin
            // A long silence re-arms the two-read lead-in.
            play_phase = PH_LEAD_A;
            low_end_t  = '0;
        end else if (play_phase == PH_LEAD_A) begin
            play_phase = PH_LEAD_B;
        end else if (player_cfg.tape_length != '0 &&
                     (play_phase == PH_IDLE || play_phase == PH_LEAD_B)) begin
            fetched    = tape_bits[tape_pos];
            play_phase = fetched ? PH_ONE : PH_ZERO;
            low_end_t  = now + player_cfg.low_time;
            bit_end_t  = now + player_cfg.zero_bit_end +
                         (fetched ? player_cfg.one_bit_extra : 16'd0);
            cap = (player_cfg.tape_length < TB_TAPE_BITS) ?
                  int'(player_cfg.tape_length) : TB_TAPE_BITS;
            if (int'(tape_pos) + 1 >= cap) begin
                tape_pos    = '0;
                res.rewound = 1'b1;
            end else begin
                tape_pos = tape_pos + 1'b1;
            end
        end
        if (play_phase == PH_ZERO || play_phase == PH_ONE) begin
            if (is_before(now, low_end_t))
                res.level = 1'b0;
            else if (is_before(now, bit_end_t))
                res.level = 1'b1;
        end
        // The bit's end can close even a lead-in that was armed just now.
        if (is_after(now, bit_end_t))
            play_phase = PH_IDLE;
        last_read_t = now;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driving. Each request is predicted as it is issued, so the expected
    // result is queued long before the core can return it.
    // ------------------------------------------------------------------------
    task automatic issue(tpb_op_t op, logic [31:0] cyc, logic [19:0] addr, logic bt,
                         bit known, tpb_result_t known_res);
        tpb_result_t res;
        bit          calm;
        if (op == OP_WRITE) begin
            // Addresses past the end of the store are dropped by the core.
            if (addr < TB_TAPE_BITS) begin
                tape_bits[addr]    = bt;
                tape_written[addr] = 1'b1;
            end
        end else begin
            res = play_read(cyc);
            pending_levels.push_back(known ? known_res : res);
        end
        calm = (requests_sent >= 500) && (requests_sent < 650);
        while (!calm && $urandom_range(0, 99) < 19) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, bt, addr, cyc};
        do
            @(posedge clk);
        while (!s_axis_tready);
        requests_sent++;
    endtask

    // Registers are only written once every read in flight has returned and
    // the pipeline has had time to drain behind a trailing write.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(tpb_cfg_idx_t idx, logic [31:0] value);
        case (idx)
            CFG_TAPE_LENGTH:   player_cfg.tape_length   = value[LEN_W-1:0];
            CFG_LOW_TIME:      player_cfg.low_time      = value[SHORT_W-1:0];
            CFG_ZERO_BIT_END:  player_cfg.zero_bit_end  = value[SHORT_W-1:0];
            CFG_ONE_BIT_EXTRA: player_cfg.one_bit_extra = value[SHORT_W-1:0];
            CFG_GAP_LIMIT:     player_cfg.gap_limit     = value;
            default: ;
        endcase
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One random request. Most reads step forward by less than a bit time so
    // that playback gets past the lead-in; the rest jump, go back in time or
    // land right on a phase boundary.
    task automatic random_request();
        logic [31:0] r32;
        logic [31:0] cyc;
        tpb_result_t none;
        int unsigned span;
        int unsigned pick;
        none = '0;
        r32  = $urandom;
        if ($urandom_range(0, 99) < 10) begin
            if ($urandom_range(0, 1) == 1)
                r32 = $urandom_range(0, TB_TAPE_BITS - 1);
            issue(OP_WRITE, $urandom, r32[19:0], 1'($urandom_range(0, 1)), 1'b0, none);
        end else begin
            // Never let playback fetch a tape bit that was never stored.
            if (player_cfg.tape_length != '0 && !tape_written[tape_pos])
                issue(OP_WRITE, $urandom, tape_pos, 1'($urandom_range(0, 1)), 1'b0, none);
            span = (int'(player_cfg.zero_bit_end) + int'(player_cfg.one_bit_extra)) / 3 + 4;
            if (span > player_cfg.gap_limit)
                span = player_cfg.gap_limit;
            pick = $urandom_range(0, 99);
            if (pick < 65)
                stim_t = stim_t + $urandom_range(0, span);
            else if (pick < 73)
                stim_t = stim_t + player_cfg.gap_limit + 32'd1 + $urandom_range(0, 2000);
            else if (pick < 80)
                stim_t = stim_t - $urandom_range(1, 300);
            else if (pick < 85)
                stim_t = $urandom;
            else begin
                case ($urandom_range(0, 3))
                    0:       stim_t = low_end_t - 32'd1;
                    1:       stim_t = low_end_t;
                    2:       stim_t = bit_end_t;
                    default: stim_t = bit_end_t + 32'd1;
                endcase
            end
            cyc = stim_t;
            issue(OP_READ, cyc, r32[19:0], r32[31], 1'b0, none);
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock and the main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        tpb_cfg_t    s;
        logic [31:0] hi;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        failures      = 0;
        requests_sent = 0;
        stim_t        = '0;
        player_cfg    = {TAPE_LENGTH_RST, LOW_TIME_RST, ZERO_BIT_END_RST,
                         ONE_BIT_EXTRA_RST, GAP_LIMIT_RST};
        play_phase    = PH_IDLE;
        last_read_t   = '0;
        low_end_t     = '0;
        bit_end_t     = '0;
        tape_pos      = '0;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. The first two reads run with the reset registers:
        // no tape, so the level is low whatever the timestamp. The writes
        // cover both tape values, the top of the store and two addresses
        // beyond it. The register writes carry junk above each field's width,
        // which the core must drop. The reads then walk a one bit and a zero bit
        // across their phase boundaries, fetch a one bit that rewinds at the tape's
        // end, and finish with a gap that re-arms the lead-in.
        directed_rows = '{
            rd_known(32'h0000_0000, 1'b0, 1'b0),
            rd_known(32'hFFFF_FFFF, 1'b0, 1'b0),
            wr(20'd0, 1'b1),
            wr(20'd1, 1'b0),
            wr(20'd2, 1'b1),
            wr(20'hF_FFFF, 1'b1),
            wr(20'd1024, 1'b1),
            wr(20'd1023, 1'b0),
            cf(CFG_TAPE_LENGTH,   32'hFFE0_0003),
            cf(CFG_LOW_TIME,      32'hABCD_0064),
            cf(CFG_ZERO_BIT_END,  32'h5A5A_03E8),
            cf(CFG_ONE_BIT_EXTRA, 32'h8000_01F4),
            cf(CFG_GAP_LIMIT,     32'd5000),
            rd(32'd100),
            rd(32'd200),
            rd(32'd350),
            rd(32'd1699),
            rd(32'd1700),
            rd(32'd1701),
            rd(32'd1800),
            rd(32'd2000),
            rd(32'd2900),
            rd(32'd3000),
            rd(32'd20000)
        };
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                settle();
                write_register(directed_rows[i].idx, directed_rows[i].value);
            end else begin
                issue(directed_rows[i].op, directed_rows[i].cyc, directed_rows[i].addr,
                      directed_rows[i].bt, directed_rows[i].known, directed_rows[i].res);
            end
        end

        // Random phases. The first two take the timing registers to their floor and
        // ceiling, with tape lengths 1 and 2^20; the third has no tape, the rest are mixed.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: s = {21'd1, 16'd0, 16'd0, 16'd0, 32'd0};
                1: s = {21'd1048576, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF};
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: s.tape_length = LEN_W'($urandom_range(1, 24));
                        5, 6, 7:       s.tape_length = LEN_W'($urandom_range(25, 1100));
                        8:             s.tape_length = 21'd1048576;
                        default:       s.tape_length = LEN_W'($urandom_range(1020, 1030));
                    endcase
                    if (ph == 2)
                        s.tape_length = '0;
                    s.low_time      = ($urandom_range(0, 4) == 0) ? SHORT_W'($urandom)
                                    : SHORT_W'($urandom_range(0, 400));
                    s.zero_bit_end  = ($urandom_range(0, 4) == 0) ? SHORT_W'($urandom)
                                    : SHORT_W'($urandom_range(0, 3000));
                    s.one_bit_extra = ($urandom_range(0, 4) == 0) ? SHORT_W'($urandom)
                                    : SHORT_W'($urandom_range(0, 2000));
                    case ($urandom_range(0, 5))
                        0:       s.gap_limit = $urandom;
                        1:       s.gap_limit = $urandom_range(0, 200);
                        default: s.gap_limit = $urandom_range(2000, 20000);
                    endcase
                end
            endcase
            hi = ($urandom_range(0, 1) == 1) ? $urandom : 32'd0;
            write_register(CFG_TAPE_LENGTH,   {hi[31:LEN_W], s.tape_length});
            write_register(CFG_LOW_TIME,      {hi[31:SHORT_W], s.low_time});
            write_register(CFG_ZERO_BIT_END,  {hi[31:SHORT_W], s.zero_bit_end});
            write_register(CFG_ONE_BIT_EXTRA, {hi[31:SHORT_W], s.one_bit_extra});
            write_register(CFG_GAP_LIMIT,     s.gap_limit);
            // Some phases start just short of the timestamp wrap.
            stim_t = ($urandom_range(0, 2) == 0) ? 32'hFFFF_F000 + $urandom_range(0, 4095)
                                                  : $urandom;
            for (int k = 0; k < PHASE_REQUESTS; k++)
                random_request();
        end

        settle();
        if (failures == 0)
            $display("tape_pulse_bit_player_core_tb passed");
        else
            $display("tape_pulse_bit_player_core_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, one long hold-off, and a calm
    // stretch with the channel always ready. Handshakes are counted here so
    // that the pattern does not depend on the checker's ordering.
    // ------------------------------------------------------------------------
    initial
    begin
        int taken;
        int hold_left;
        taken         = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                taken++;
                if (taken == HOLD_AT_RESULT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (taken >= 450 && taken < 600) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= 19);
            end
        end
    end

    // Each accepted result is compared field by field with the oldest one
    // owed; a result with nothing owed is a failure in itself.
    always @(posedge clk)
    begin : result_check
        tpb_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_levels.size() == 0) begin
                $error("unexpected result: tdata %h", m_axis_tdata);
                failures++;
            end else begin
                want = pending_levels.pop_front();
                if (m_axis_tdata[0] !== want.level) begin
                    $error("level: expected %b, actual %b", want.level, m_axis_tdata[0]);
                    failures++;
                end
                if (m_axis_tdata[1] !== want.rewound) begin
                    $error("rewound: expected %b, actual %b", want.rewound, m_axis_tdata[1]);
                    failures++;
                end
                if (m_axis_tdata[OUT_TDATA_W-1:2] !== '0) begin
                    $error("pad: expected %h, actual %h", 6'h00, m_axis_tdata[OUT_TDATA_W-1:2]);
                    failures++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("tape_pulse_bit_player_core_tb failed");
        $finish;
    end

endmodule
